// ----- hdl/pqs_pkg.sv -----
// ----------------------------------------------------------------------------
// pqs_pkg
// Shared widths, codes, entry layout and helpers of the path quality selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pqs_pkg;

  // Field widths
  localparam int unsigned ACT_W      = 3;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned COST_W     = 16;
  localparam int unsigned VER_W      = 16;
  localparam int unsigned ARCH_W     = 2;
  localparam int unsigned QST_W      = 2;
  localparam int unsigned RTT_W      = 32;
  localparam int unsigned STAT_W     = 3;
  localparam int unsigned SCORE_W    = 19;
  localparam int unsigned PERM_W     = 10;
  localparam int unsigned WGT_W      = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned SUM_W      = 64;
  localparam int unsigned DVD_W      = 64;
  localparam int unsigned DVS_W      = 32;

  localparam int unsigned MAX_PATHS_DEF = 16;

  // Normalizing ceilings
  localparam logic [DVS_W-1:0] RTT_CEIL = 32'd1000000;
  localparam logic [DVS_W-1:0] JIT_CEIL = 32'd500000;

  // Actions
  localparam logic [ACT_W-1:0] ACT_ADD      = 3'd0;
  localparam logic [ACT_W-1:0] ACT_SET_ARCH = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SET_QOS  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_RECORD   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_QUERY    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_BEST     = 3'd5;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] ST_BAD_SLOT  = 3'd2;
  localparam logic [STAT_W-1:0] ST_BAD_VALUE = 3'd3;
  localparam logic [STAT_W-1:0] ST_NO_PATH   = 3'd4;

  // QoS architectures
  localparam logic [ARCH_W-1:0] ARCH_BE       = 2'd0;
  localparam logic [ARCH_W-1:0] ARCH_DIFFSERV = 2'd1;
  localparam logic [ARCH_W-1:0] ARCH_INTSERV  = 2'd2;
  localparam logic [ARCH_W-1:0] ARCH_MPLS     = 2'd3;

  // QoS states
  localparam logic [QST_W-1:0] QS_REQUESTED = 2'd0;
  localparam logic [QST_W-1:0] QS_REALIZED  = 2'd1;
  localparam logic [QST_W-1:0] QS_DENIED    = 2'd2;
  localparam logic [QST_W-1:0] QS_INVALID   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_W_DATA    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_W_CERT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_W_COST    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_W_VERSION = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_W_ARCH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VER   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COST_LIM  = 3'd6;

  localparam logic [WGT_W-1:0] WGT_MAX = 7'd100;

  // One table entry as held in the entry memory
  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [VER_W-1:0]  version;
    logic [ARCH_W-1:0] arch;
    logic [QST_W-1:0]  qst;
    logic [CNT_W-1:0]  sent;
    logic [CNT_W-1:0]  rep;
    logic [SUM_W-1:0]  rtt_sum;
    logic [RTT_W-1:0]  prev_rtt;
    logic              prev_valid;
    logic [SUM_W-1:0]  jit_sum;
    logic [CNT_W-1:0]  jit_cnt;
  } pqs_entry_t;

  // Saturate a quotient to 32 bits
  function automatic logic [RTT_W-1:0] clamp32(input logic [DVD_W-1:0] q);
    return (q[DVD_W-1:RTT_W] != '0) ? '1 : q[RTT_W-1:0];
  endfunction

  // Architecture fitness term, 200..1000
  function automatic logic [PERM_W-1:0] arch_term(input logic [ARCH_W-1:0] arch,
                                                   input logic [QST_W-1:0]  qst);
    logic [PERM_W-1:0] base;
    logic [PERM_W-1:0] req;
    logic [PERM_W-1:0] res;
    case (arch)
      ARCH_DIFFSERV: begin base = 10'd600;  req = 10'd450; end
      ARCH_INTSERV:  begin base = 10'd1000; req = 10'd550; end
      ARCH_MPLS:     begin base = 10'd800;  req = 10'd500; end
      default:       begin base = 10'd400;  req = 10'd400; end
    endcase
    case (qst)
      QS_REALIZED: res = base;
      QS_DENIED:   res = 10'd200;
      default:     res = req;
    endcase
    if (arch == ARCH_BE) begin
      res = 10'd400;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/pqs_div.sv -----
// ----------------------------------------------------------------------------
// pqs_div
// Restoring divider, one quotient bit per cycle, 64-bit by 32-bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pqs_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [pqs_pkg::DVD_W-1:0] dividend_i,
  input  logic [pqs_pkg::DVS_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [pqs_pkg::DVD_W-1:0] quotient_o
);
  import pqs_pkg::*;

  localparam int unsigned STEP_W = $clog2(DVD_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DVD_W - 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [DVS_W:0]    rem_q;
  logic [DVD_W-1:0]  quo_q;
  logic [DVS_W-1:0]  dvs_q;

  logic [DVS_W:0]    rem_sh;
  logic              take;

  // Shift in the next dividend bit and try the subtract
  assign rem_sh = {rem_q[DVS_W-1:0], quo_q[DVD_W-1]};
  assign take   = rem_sh >= {1'b0, dvs_q};

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= take ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      quo_q <= {quo_q[DVD_W-2:0], take};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ----- hdl/path_quality_best_selector.sv -----
// ----------------------------------------------------------------------------
// path_quality_best_selector
// Path table with round-trip statistics, weighted scoring and best selection.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_ready_o   | action, slot, cost, version, qos, rtt, lost
//  out     | output    | out_valid_o/out_ready_i | status, slot, score, statistics
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  Query runs five divisions (mean, loss, jitter, delivery, cost) through the
//  shared 64-step divider. Best runs the same five for each entry that passes
//  the version and cost gates and skips the other entries.
//  One item is in work at a time; the next is taken while a result waits.
//  Reset empties the table and restores the default weights; the entry memory
//  is not cleared. Configuration beats are always taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module path_quality_best_selector #(
  parameter int unsigned MAX_PATHS = pqs_pkg::MAX_PATHS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [pqs_pkg::ACT_W-1:0]      action_i,
  input  logic [pqs_pkg::SLOT_W-1:0]     slot_i,
  input  logic [pqs_pkg::COST_W-1:0]     path_cost_i,
  input  logic [pqs_pkg::VER_W-1:0]      path_version_i,
  input  logic [pqs_pkg::ARCH_W-1:0]     qos_arch_i,
  input  logic [pqs_pkg::QST_W-1:0]      qos_state_in_i,
  input  logic [pqs_pkg::RTT_W-1:0]      rtt_us_i,
  input  logic                           lost_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [pqs_pkg::STAT_W-1:0]     status_o,
  output logic [pqs_pkg::SLOT_W-1:0]     result_slot_o,
  output logic [pqs_pkg::SCORE_W-1:0]    score_o,
  output logic [pqs_pkg::RTT_W-1:0]      mean_rtt_us_o,
  output logic                           mean_valid_o,
  output logic [pqs_pkg::PERM_W-1:0]     loss_permille_o,
  output logic [pqs_pkg::RTT_W-1:0]      jitter_us_o,
  output logic [pqs_pkg::PERM_W-1:0]     certainty_permille_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pqs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pqs_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import pqs_pkg::*;

  localparam int unsigned IW   = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;
  localparam int unsigned CW   = $clog2(MAX_PATHS + 1);
  localparam int unsigned CMPW = (CW > SLOT_W) ? CW : SLOT_W;
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_PATHS);

  // Reciprocals: 3*x/5000 with a 34-bit shift, x/1000 with a 30-bit shift
  localparam logic [21:0] PEN_RECIP  = 22'd3435974;
  localparam logic [20:0] GOOD_RECIP = 21'd1073742;

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_MOD   = 4'd2;
  localparam logic [3:0] S_REC   = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_GATE  = 4'd5;
  localparam logic [3:0] S_LOAD  = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_TERM  = 4'd8;
  localparam logic [3:0] S_MUL   = 4'd9;
  localparam logic [3:0] S_SUM   = 4'd10;
  localparam logic [3:0] S_PICK  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;
  localparam logic [3:0] S_RECIP = 4'd13;

  // Division jobs of one statistics pass
  localparam logic [2:0] DK_MEAN  = 3'd0;
  localparam logic [2:0] DK_LOSS  = 3'd1;
  localparam logic [2:0] DK_JIT   = 3'd2;
  localparam logic [2:0] DK_DELIV = 3'd3;
  localparam logic [2:0] DK_COST  = 3'd4;

  // Control state
  logic [3:0]    state_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] scan_q;
  logic [2:0]    dk_q;
  logic          found_q;
  logic          out_valid_q;

  // Configuration
  logic [WGT_W-1:0]  w_data_q, w_cert_q, w_cost_q, w_ver_q, w_arch_q;
  logic [VER_W-1:0]  minv_q;
  logic [COST_W-1:0] climit_q;
  logic [WGT_W-1:0]  cfg_wgt;

  // Captured item
  logic [ACT_W-1:0]  act_q;
  logic [SLOT_W-1:0] slot_q;
  logic [COST_W-1:0] cost_in_q;
  logic [VER_W-1:0]  ver_in_q;
  logic [ARCH_W-1:0] arch_in_q;
  logic [QST_W-1:0]  qst_in_q;
  logic [RTT_W-1:0]  rtt_q;
  logic              lost_q;

  // Entry memory
  pqs_entry_t        entry_mem_q [MAX_PATHS];
  pqs_entry_t        rd_q;
  logic              mem_we, mem_re;
  logic [IW-1:0]     mem_wa, mem_ra;
  pqs_entry_t        mem_wd;
  pqs_entry_t        init_entry, arch_entry, qos_entry, rec_entry;
  logic [RTT_W-1:0]  diff_q;
  logic [SUM_W:0]    rtt_sum_add, jit_sum_add;

  // Statistics and score
  logic [RTT_W-1:0]   mean_q, jit_q;
  logic [PERM_W-1:0]  loss_q, deliv_q, good_q, costt_q;
  logic [8:0]         pen_q;
  logic [PERM_W-1:0]  data_t_q, cert_t_q, vers_t_q, arch_t_q;
  logic [16:0]        p_data_q, p_cert_q, p_cost_q, p_ver_q, p_arch_q;
  logic [SCORE_W-1:0] score_q, best_score_q;
  logic [10:0]        data_sum;
  logic [VER_W-1:0]   vdiff;
  logic [20:0]        pen_x;
  logic [42:0]        pen_p;
  logic [40:0]        good_p;

  // Divider feed
  logic [RTT_W-1:0] mul_a;
  logic [9:0]       mul_b;
  logic [41:0]      mul_p;
  logic             use_mul;
  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic             div_start, div_done;
  logic [DVD_W-1:0] div_q;

  // Pending result and output register
  logic [STAT_W-1:0]  res_status_q, out_status_q;
  logic [SLOT_W-1:0]  res_slot_q, out_slot_q;
  logic [SCORE_W-1:0] res_score_q, out_score_q;
  logic [RTT_W-1:0]   res_mean_q, out_mean_q;
  logic               res_mvalid_q, out_mvalid_q;
  logic [PERM_W-1:0]  res_loss_q, out_loss_q;
  logic [RTT_W-1:0]   res_jit_q, out_jit_q;
  logic [PERM_W-1:0]  res_cert_q, out_cert_q;

  // Decode helpers
  logic          slot_ok, slot_act, dec_read, gate_ok, better, in_fire, out_free;
  logic [IW-1:0] slot_idx;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  assign slot_ok  = CMPW'(slot_q) < CMPW'(count_q);
  assign slot_idx = IW'(slot_q);
  assign slot_act = act_q inside {ACT_SET_ARCH, ACT_SET_QOS, ACT_RECORD, ACT_QUERY};
  assign dec_read = slot_act && slot_ok &&
                    !(act_q == ACT_SET_QOS && qst_in_q == QS_INVALID);
  assign gate_ok  = (rd_q.version >= minv_q) && (climit_q == '0 || rd_q.cost <= climit_q);
  assign better   = !found_q || (score_q > best_score_q);
  assign cfg_wgt  = (cfg_data_i[WGT_W-1:0] > WGT_MAX) ? WGT_MAX : cfg_data_i[WGT_W-1:0];

  // Build the entries to write back
  assign rtt_sum_add = {1'b0, rd_q.rtt_sum} + (SUM_W + 1)'(rtt_q);
  assign jit_sum_add = {1'b0, rd_q.jit_sum} + (SUM_W + 1)'(diff_q);

  always_comb begin
    init_entry         = '0;
    init_entry.cost    = cost_in_q;
    init_entry.version = ver_in_q;

    arch_entry      = rd_q;
    arch_entry.arch = arch_in_q;
    arch_entry.qst  = (qst_in_q == QS_INVALID) ? QS_REQUESTED : qst_in_q;

    qos_entry     = rd_q;
    qos_entry.qst = qst_in_q;

    rec_entry      = rd_q;
    rec_entry.sent = (rd_q.sent == '1) ? rd_q.sent : rd_q.sent + 1'b1;
    if (!lost_q) begin
      rec_entry.rep     = (rd_q.rep == '1) ? rd_q.rep : rd_q.rep + 1'b1;
      rec_entry.rtt_sum = rtt_sum_add[SUM_W] ? '1 : rtt_sum_add[SUM_W-1:0];
      if (rd_q.prev_valid) begin
        rec_entry.jit_sum = jit_sum_add[SUM_W] ? '1 : jit_sum_add[SUM_W-1:0];
        rec_entry.jit_cnt = (rd_q.jit_cnt == '1) ? rd_q.jit_cnt : rd_q.jit_cnt + 1'b1;
      end
      rec_entry.prev_rtt   = rtt_q;
      rec_entry.prev_valid = 1'b1;
    end
  end

  // Memory port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = slot_idx;
    mem_wd = rd_q;
    mem_re = 1'b0;
    mem_ra = slot_idx;
    unique case (state_q)
      S_DEC: begin
        if (act_q == ACT_ADD && count_q < COUNT_MAX) begin
          mem_we = 1'b1;
          mem_wa = IW'(count_q);
          mem_wd = init_entry;
        end else if (dec_read) begin
          mem_re = 1'b1;
        end
      end
      S_MOD: begin
        if (act_q == ACT_SET_ARCH) begin
          mem_we = 1'b1;
          mem_wd = arch_entry;
        end else if (act_q == ACT_SET_QOS) begin
          mem_we = 1'b1;
          mem_wd = qos_entry;
        end
      end
      S_REC: begin
        mem_we = 1'b1;
        mem_wd = rec_entry;
      end
      S_SCAN: begin
        mem_re = (scan_q < count_q);
        mem_ra = IW'(scan_q);
      end
      default: ;
    endcase
  end

  // Entry memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= entry_mem_q[mem_ra];
    end
  end

  // Select multiplier operands for the current division job
  always_comb begin
    mul_a   = '0;
    mul_b   = 10'd1000;
    use_mul = 1'b1;
    case (dk_q)
      DK_LOSS:  mul_a = rd_q.sent - rd_q.rep;
      DK_DELIV: mul_a = rd_q.rep;
      DK_COST:  mul_a = RTT_W'(rd_q.cost);
      default:  use_mul = 1'b0;
    endcase
  end

  assign mul_p = 42'(mul_a) * 42'(mul_b);

  // Select dividend and divisor
  always_comb begin
    dvd = use_mul ? DVD_W'(mul_p) : '0;
    dvs = rd_q.sent;
    case (dk_q)
      DK_MEAN: begin
        dvd = rd_q.rtt_sum;
        dvs = rd_q.rep;
      end
      DK_JIT: begin
        dvd = rd_q.jit_sum;
        dvs = rd_q.jit_cnt;
      end
      DK_COST: dvs = (climit_q != '0) ? DVS_W'(climit_q) : 32'd1000;
      default: ;
    endcase
  end

  assign div_start = (state_q == S_LOAD);

  pqs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // Constant divisions by reciprocal multiply
  assign pen_x  = 21'(jit_q[18:0]) * 21'd3;
  assign pen_p  = 43'(pen_x) * 43'(PEN_RECIP);
  assign good_p = 41'(mean_q[19:0]) * 41'(GOOD_RECIP);

  // Term helpers
  assign data_sum = 11'(good_q) + 11'd1000 - 11'(loss_q);
  assign vdiff    = rd_q.version - minv_q;

  // Sequencer and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      dk_q        <= DK_MEAN;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      w_data_q    <= 7'd45;
      w_cert_q    <= 7'd25;
      w_cost_q    <= 7'd10;
      w_ver_q     <= 7'd5;
      w_arch_q    <= 7'd15;
      minv_q      <= '0;
      climit_q    <= '0;
    end else begin
      // Take configuration beats
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_W_DATA:    w_data_q <= cfg_wgt;
          CFG_W_CERT:    w_cert_q <= cfg_wgt;
          CFG_W_COST:    w_cost_q <= cfg_wgt;
          CFG_W_VERSION: w_ver_q  <= cfg_wgt;
          CFG_W_ARCH:    w_arch_q <= cfg_wgt;
          CFG_MIN_VER:   minv_q   <= cfg_data_i;
          CFG_COST_LIM:  climit_q <= cfg_data_i;
          default: ;
        endcase
      end

      // Drop the output beat once taken, unless a new one replaces it
      if (out_valid_q && out_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_DEC;
        S_DEC: begin
          unique case (act_q) inside
            ACT_ADD: begin
              if (count_q < COUNT_MAX) count_q <= count_q + 1'b1;
              state_q <= S_DONE;
            end
            ACT_SET_ARCH, ACT_SET_QOS, ACT_RECORD, ACT_QUERY: begin
              state_q <= dec_read ? S_MOD : S_DONE;
            end
            ACT_BEST: begin
              scan_q  <= '0;
              found_q <= 1'b0;
              state_q <= S_SCAN;
            end
            default: state_q <= S_DONE;
          endcase
        end
        S_MOD: begin
          if (act_q == ACT_RECORD) begin
            state_q <= S_REC;
          end else if (act_q == ACT_QUERY) begin
            dk_q    <= DK_MEAN;
            state_q <= S_LOAD;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_REC:  state_q <= S_DONE;
        S_SCAN: state_q <= (scan_q < count_q) ? S_GATE : S_DONE;
        S_GATE: begin
          if (gate_ok) begin
            dk_q    <= DK_MEAN;
            state_q <= S_LOAD;
          end else begin
            scan_q  <= scan_q + 1'b1;
            state_q <= S_SCAN;
          end
        end
        S_LOAD: state_q <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            if (dk_q == DK_COST) begin
              state_q <= S_RECIP;
            end else begin
              dk_q    <= dk_q + 1'b1;
              state_q <= S_LOAD;
            end
          end
        end
        S_RECIP: state_q <= S_TERM;
        S_TERM:  state_q <= S_MUL;
        S_MUL:   state_q <= S_SUM;
        S_SUM:   state_q <= S_PICK;
        S_PICK: begin
          if (act_q == ACT_QUERY) begin
            state_q <= S_DONE;
          end else begin
            if (better) found_q <= 1'b1;
            scan_q  <= scan_q + 1'b1;
            state_q <= S_SCAN;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          act_q        <= action_i;
          slot_q       <= slot_i;
          cost_in_q    <= path_cost_i;
          ver_in_q     <= path_version_i;
          arch_in_q    <= qos_arch_i;
          qst_in_q     <= qos_state_in_i;
          rtt_q        <= rtt_us_i;
          lost_q       <= lost_i;
          res_status_q <= ST_OK;
          res_slot_q   <= '0;
          res_score_q  <= '0;
          res_mean_q   <= '0;
          res_mvalid_q <= 1'b0;
          res_loss_q   <= '0;
          res_jit_q    <= '0;
          res_cert_q   <= '0;
        end
      end
      S_DEC: begin
        if (act_q == ACT_ADD) begin
          if (count_q < COUNT_MAX) res_slot_q <= SLOT_W'(count_q);
          else res_status_q <= ST_FULL;
        end else if (slot_act) begin
          res_slot_q <= slot_q;
          if (!slot_ok) res_status_q <= ST_BAD_SLOT;
          else if (act_q == ACT_SET_QOS && qst_in_q == QS_INVALID) res_status_q <= ST_BAD_VALUE;
        end else if (act_q != ACT_BEST) begin
          res_status_q <= ST_BAD_VALUE;
        end
      end
      // Absolute step between successive round trips
      S_MOD: diff_q <= (rtt_q >= rd_q.prev_rtt) ? rtt_q - rd_q.prev_rtt : rd_q.prev_rtt - rtt_q;
      S_SCAN: begin
        if (!(scan_q < count_q) && !found_q) res_status_q <= ST_NO_PATH;
      end
      S_DIV: begin
        if (div_done) begin
          case (dk_q)
            DK_MEAN:  mean_q  <= (rd_q.rep == '0) ? '0 : clamp32(div_q);
            DK_LOSS:  loss_q  <= (rd_q.sent == '0) ? '0 : div_q[PERM_W-1:0];
            DK_JIT:   jit_q   <= (rd_q.jit_cnt == '0) ? '0 : clamp32(div_q);
            DK_DELIV: deliv_q <= div_q[PERM_W-1:0];
            default:  costt_q <= (div_q >= 64'd1000) ? '0 : 10'd1000 - div_q[PERM_W-1:0];
          endcase
        end
      end
      // Jitter penalty and delay goodness from the reciprocal products
      S_RECIP: begin
        pen_q  <= (jit_q >= JIT_CEIL) ? 9'd300 : pen_p[42:34];
        good_q <= (mean_q >= RTT_CEIL) ? '0 : 10'd1000 - good_p[39:30];
      end
      S_TERM: begin
        data_t_q <= (rd_q.rep != '0) ? data_sum[10:1] : '0;
        cert_t_q <= (rd_q.sent == '0 || deliv_q <= 10'(pen_q)) ? '0 : deliv_q - 10'(pen_q);
        if (rd_q.version < minv_q) vers_t_q <= '0;
        else if (vdiff >= 16'd5) vers_t_q <= 10'd1000;
        else vers_t_q <= 10'd500 + 10'(vdiff[2:0]) * 10'd100;
        arch_t_q <= arch_term(rd_q.arch, rd_q.qst);
      end
      S_MUL: begin
        p_data_q <= 17'(w_data_q) * 17'(data_t_q);
        p_cert_q <= 17'(w_cert_q) * 17'(cert_t_q);
        p_cost_q <= 17'(w_cost_q) * 17'(costt_q);
        p_ver_q  <= 17'(w_ver_q) * 17'(vers_t_q);
        p_arch_q <= 17'(w_arch_q) * 17'(arch_t_q);
      end
      S_SUM: begin
        score_q <= 19'(p_data_q) + 19'(p_cert_q) + 19'(p_cost_q) + 19'(p_ver_q)
                 + 19'(p_arch_q);
      end
      S_PICK: begin
        if (act_q == ACT_QUERY || better) begin
          best_score_q <= score_q;
          res_score_q  <= score_q;
          res_mean_q   <= mean_q;
          res_mvalid_q <= (rd_q.rep != '0);
          res_loss_q   <= loss_q;
          res_jit_q    <= jit_q;
          res_cert_q   <= cert_t_q;
          if (act_q != ACT_QUERY) res_slot_q <= SLOT_W'(scan_q);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_status_q <= res_status_q;
          out_slot_q   <= res_slot_q;
          out_score_q  <= res_score_q;
          out_mean_q   <= res_mean_q;
          out_mvalid_q <= res_mvalid_q;
          out_loss_q   <= res_loss_q;
          out_jit_q    <= res_jit_q;
          out_cert_q   <= res_cert_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = out_status_q;
  assign result_slot_o        = out_slot_q;
  assign score_o              = out_score_q;
  assign mean_rtt_us_o        = out_mean_q;
  assign mean_valid_o         = out_mvalid_q;
  assign loss_permille_o      = out_loss_q;
  assign jitter_us_o          = out_jit_q;
  assign certainty_permille_o = out_cert_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_MAX)
    else $error("entry count beyond table size");

  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEC && act_q == ACT_ADD && count_q < COUNT_MAX)
      |=> (count_q == CW'($past(count_q) + 1'b1)))
    else $error("add with room did not grow the table");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=> out_valid_q)
    else $error("finished result not presented");

  a_div_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside its wait state");

  a_no_path_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == ST_NO_PATH) |-> (out_score_q == '0 && out_slot_q == '0))
    else $error("no-path result carries data");

endmodule

`default_nettype wire

// ----- test/path_quality_best_selector_tb.sv -----
// ----------------------------------------------------------------------------
// path_quality_best_selector_tb
// Self-checking bench for the path quality selector. A behavioral predictor
// tracks the path table, the round-trip accumulators and the weights.
// Directed tests cover the empty table, table fill, every action and the
// error codes. Random traffic then runs under several weight, version and
// cost settings while both channels idle at random, but for one steady phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module path_quality_best_selector_tb;
  import pqs_pkg::*;

  localparam logic [ACT_W-1:0] ACT_RSVD_A = 3'd6;
  localparam logic [ACT_W-1:0] ACT_RSVD_B = 3'd7;
  localparam int unsigned NPATH = MAX_PATHS_DEF;
  localparam longint unsigned CYCLE_LIMIT = 64'd40000000;
  localparam longint unsigned U32M = 64'hFFFF_FFFF;
  localparam longint unsigned U64M = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [ACT_W-1:0]  action;
    logic [SLOT_W-1:0] slot;
    logic [COST_W-1:0] cost;
    logic [VER_W-1:0]  version;
    logic [ARCH_W-1:0] arch;
    logic [QST_W-1:0]  qst;
    logic [RTT_W-1:0]  rtt;
    logic              lost;
  } probe_item_t;

  typedef struct {
    logic [STAT_W-1:0]  status;
    logic [SLOT_W-1:0]  slot;
    logic [SCORE_W-1:0] score;
    logic [RTT_W-1:0]   mean;
    logic               mean_valid;
    logic [PERM_W-1:0]  loss;
    logic [RTT_W-1:0]   jitter;
    logic [PERM_W-1:0]  certainty;
  } path_report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [ACT_W-1:0] action_i = '0;
  logic [SLOT_W-1:0] slot_i = '0;
  logic [COST_W-1:0] path_cost_i = '0;
  logic [VER_W-1:0] path_version_i = '0;
  logic [ARCH_W-1:0] qos_arch_i = '0;
  logic [QST_W-1:0] qos_state_in_i = '0;
  logic [RTT_W-1:0] rtt_us_i = '0;
  logic lost_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [STAT_W-1:0] status_o;
  logic [SLOT_W-1:0] result_slot_o;
  logic [SCORE_W-1:0] score_o;
  logic [RTT_W-1:0] mean_rtt_us_o;
  logic mean_valid_o;
  logic [PERM_W-1:0] loss_permille_o;
  logic [RTT_W-1:0] jitter_us_o;
  logic [PERM_W-1:0] certainty_permille_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  path_quality_best_selector u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .action_i, .slot_i, .path_cost_i,
    .path_version_i, .qos_arch_i, .qos_state_in_i, .rtt_us_i, .lost_i,
    .out_valid_o, .out_ready_i, .status_o, .result_slot_o, .score_o,
    .mean_rtt_us_o, .mean_valid_o, .loss_permille_o, .jitter_us_o,
    .certainty_permille_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #2 clk_i = ~clk_i;

  // Predictor state: weights, gates and path table
  longint unsigned wgt [5];
  longint unsigned min_ver, cost_lim;
  int unsigned path_count;
  longint unsigned p_cost [NPATH], p_ver [NPATH], p_arch [NPATH], p_qst [NPATH];
  longint unsigned p_sent [NPATH], p_rep [NPATH], p_rtt_sum [NPATH];
  longint unsigned p_prev [NPATH], p_jit_sum [NPATH], p_jit_cnt [NPATH];
  bit p_prev_ok [NPATH];

  path_report_t pending_reports [$];
  int unsigned fail_count = 0;
  bit steady = 1'b0;
  longint unsigned cycles = 0;

  function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b,
                                              longint unsigned lim);
    return (b > lim - a) ? lim : a + b;
  endfunction

  function automatic longint unsigned mean_rtt(int i);
    longint unsigned m;
    if (p_rep[i] == 0) return 0;
    m = p_rtt_sum[i] / p_rep[i];
    return (m > U32M) ? U32M : m;
  endfunction

  function automatic longint unsigned loss_pm(int i);
    if (p_sent[i] == 0) return 0;
    return ((p_sent[i] - p_rep[i]) * 1000) / p_sent[i];
  endfunction

  function automatic longint unsigned mean_jitter(int i);
    longint unsigned j;
    if (p_jit_cnt[i] == 0) return 0;
    j = p_jit_sum[i] / p_jit_cnt[i];
    return (j > U32M) ? U32M : j;
  endfunction

  function automatic longint unsigned certainty_pm(int i);
    longint unsigned dlv, pen;
    if (p_sent[i] == 0) return 0;
    dlv = (p_rep[i] * 1000) / p_sent[i];
    pen = (mean_jitter(i) * 300) / 500000;
    if (pen > 300) pen = 300;
    return (dlv > pen) ? dlv - pen : 0;
  endfunction

  function automatic longint unsigned qos_term(int i);
    longint unsigned base;
    case (p_arch[i])
      ARCH_DIFFSERV: base = 600;
      ARCH_INTSERV:  base = 1000;
      ARCH_MPLS:     base = 800;
      default:       return 400;
    endcase
    if (p_qst[i] == QS_REALIZED) return base;
    if (p_qst[i] == QS_DENIED) return 200;
    return 400 + (base - 400) / 4;
  endfunction

  function automatic longint unsigned path_score(int i);
    longint unsigned data, costn, vers, ref_cost, m, good;
    data = 0;
    vers = 0;
    if (p_rep[i] > 0) begin
      m = mean_rtt(i);
      good = (m >= 1000000) ? 0 : 1000 - (m * 1000) / 1000000;
      data = (good + (1000 - loss_pm(i))) / 2;
    end
    ref_cost = (cost_lim > 0) ? cost_lim : 1000;
    costn = (p_cost[i] * 1000) / ref_cost;
    if (costn > 1000) costn = 1000;
    if (p_ver[i] >= min_ver) begin
      vers = 500 + (p_ver[i] - min_ver) * 100;
      if (vers > 1000) vers = 1000;
    end
    return wgt[0] * data + wgt[1] * certainty_pm(i) + wgt[2] * (1000 - costn)
         + wgt[3] * vers + wgt[4] * qos_term(i);
  endfunction

  function automatic void fill_report(int i, ref path_report_t r);
    r.score      = SCORE_W'(path_score(i));
    r.mean       = RTT_W'(mean_rtt(i));
    r.mean_valid = (p_rep[i] > 0);
    r.loss       = PERM_W'(loss_pm(i));
    r.jitter     = RTT_W'(mean_jitter(i));
    r.certainty  = PERM_W'(certainty_pm(i));
  endfunction

  // Apply one accepted beat to the predicted table and return its report
  function automatic path_report_t apply_item(probe_item_t it);
    path_report_t r;
    bit ok;
    int s, best;
    longint unsigned d, sc, best_sc;
    bit found;
    r = '{default: '0};
    s = it.slot;
    ok = (s < path_count);
    case (it.action)
      ACT_ADD: begin
        if (path_count >= NPATH) begin
          r.status = ST_FULL;
        end else begin
          s = path_count;
          p_cost[s] = it.cost; p_ver[s] = it.version;
          p_arch[s] = ARCH_BE; p_qst[s] = QS_REQUESTED;
          p_sent[s] = 0; p_rep[s] = 0; p_rtt_sum[s] = 0; p_prev[s] = 0;
          p_prev_ok[s] = 0; p_jit_sum[s] = 0; p_jit_cnt[s] = 0;
          path_count++;
          r.slot = SLOT_W'(s);
        end
      end
      ACT_SET_ARCH: begin
        r.slot = SLOT_W'(s);
        if (!ok) r.status = ST_BAD_SLOT;
        else begin
          p_arch[s] = it.arch;
          p_qst[s] = (it.qst == QS_INVALID) ? QS_REQUESTED : it.qst;
        end
      end
      ACT_SET_QOS: begin
        r.slot = SLOT_W'(s);
        if (!ok) r.status = ST_BAD_SLOT;
        else if (it.qst == QS_INVALID) r.status = ST_BAD_VALUE;
        else p_qst[s] = it.qst;
      end
      ACT_RECORD: begin
        r.slot = SLOT_W'(s);
        if (!ok) r.status = ST_BAD_SLOT;
        else begin
          p_sent[s] = sat_sum(p_sent[s], 1, U32M);
          if (!it.lost) begin
            p_rep[s] = sat_sum(p_rep[s], 1, U32M);
            p_rtt_sum[s] = sat_sum(p_rtt_sum[s], it.rtt, U64M);
            if (p_prev_ok[s]) begin
              d = (it.rtt >= p_prev[s]) ? it.rtt - p_prev[s] : p_prev[s] - it.rtt;
              p_jit_sum[s] = sat_sum(p_jit_sum[s], d, U64M);
              p_jit_cnt[s] = sat_sum(p_jit_cnt[s], 1, U32M);
            end
            p_prev[s] = it.rtt;
            p_prev_ok[s] = 1;
          end
        end
      end
      ACT_QUERY: begin
        r.slot = SLOT_W'(s);
        if (!ok) r.status = ST_BAD_SLOT;
        else fill_report(s, r);
      end
      ACT_BEST: begin
        found = 0; best = 0; best_sc = 0;
        for (int i = 0; i < path_count; i++) begin
          if (p_ver[i] < min_ver) continue;
          if (cost_lim > 0 && p_cost[i] > cost_lim) continue;
          sc = path_score(i);
          if (!found || sc > best_sc) begin
            found = 1; best_sc = sc; best = i;
          end
        end
        if (!found) r.status = ST_NO_PATH;
        else begin
          r.slot = SLOT_W'(best);
          fill_report(best, r);
        end
      end
      default: r.status = ST_BAD_VALUE;
    endcase
    return r;
  endfunction

  // Send one beat; an optional idle gap comes first
  task automatic send_item(probe_item_t it);
    int gap;
    gap = (!steady && $urandom_range(0, 99) < 23) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= it.action;
    slot_i         <= it.slot;
    path_cost_i    <= it.cost;
    path_version_i <= it.version;
    qos_arch_i     <= it.arch;
    qos_state_in_i <= it.qst;
    rtt_us_i       <= it.rtt;
    lost_i         <= it.lost;
    do @(posedge clk_i); while (!in_ready_o);
    pending_reports.push_back(apply_item(it));
  endtask

  task automatic send_op(logic [ACT_W-1:0] act, int slot, int cost = 0, int ver = 0,
                         int arch = 0, int qst = 0, logic [RTT_W-1:0] rtt = '0,
                         bit lost = 0);
    probe_item_t it;
    it = '{act, SLOT_W'(slot), COST_W'(cost), VER_W'(ver), ARCH_W'(arch), QST_W'(qst),
           rtt, lost};
    send_item(it);
  endtask

  // Hold the sender until every expected report has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_MIN_VER:  min_ver = val;
      CFG_COST_LIM: cost_lim = val;
      default: wgt[idx] = (val[6:0] > WGT_MAX) ? WGT_MAX : val[6:0];
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_weights(int wd, int wc, int wk, int wv, int wa, int mv, int cl);
    drain();
    write_reg(CFG_W_DATA, CFG_DATA_W'(wd));
    write_reg(CFG_W_CERT, CFG_DATA_W'(wc));
    write_reg(CFG_W_COST, CFG_DATA_W'(wk));
    write_reg(CFG_W_VERSION, CFG_DATA_W'(wv));
    write_reg(CFG_W_ARCH, CFG_DATA_W'(wa));
    write_reg(CFG_MIN_VER, CFG_DATA_W'(mv));
    write_reg(CFG_COST_LIM, CFG_DATA_W'(cl));
  endtask

  // Every action but add against an empty table, for the bad-slot, no-path and bad-value codes
  task automatic test_empty_table();
    send_op(ACT_QUERY, 0);
    send_op(ACT_SET_ARCH, 3, 0, 0, ARCH_MPLS, QS_REALIZED);
    send_op(ACT_SET_QOS, 15, 0, 0, 0, QS_DENIED);
    send_op(ACT_RECORD, 15, 0, 0, 0, 0, 32'hFFFF_FFFF, 1'b1);
    send_op(ACT_BEST, 0);
    send_op(ACT_RSVD_A, 0);
    send_op(ACT_RSVD_B, 15, 16'hFFFF, 16'hFFFF, 3, 3, 32'hFFFF_FFFF, 1'b1);
  endtask

  // Exercise adds, sets, records, queries and selection, then fill the table and overflow it
  task automatic test_fill_and_actions();
    send_op(ACT_ADD, 0, 0, 0);
    send_op(ACT_ADD, 0, 16'hFFFF, 16'hFFFF);
    send_op(ACT_ADD, 0, 999, 3);
    send_op(ACT_SET_ARCH, 0, 0, 0, ARCH_INTSERV, QS_INVALID);
    send_op(ACT_SET_ARCH, 1, 0, 0, ARCH_DIFFSERV, QS_REALIZED);
    send_op(ACT_SET_QOS, 1, 0, 0, 0, QS_INVALID);
    send_op(ACT_SET_QOS, 0, 0, 0, 0, QS_DENIED);
    send_op(ACT_RECORD, 0, 0, 0, 0, 0, 32'd0);
    send_op(ACT_RECORD, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
    send_op(ACT_RECORD, 0, 0, 0, 0, 0, 32'd0, 1'b1);
    send_op(ACT_QUERY, 0);
    send_op(ACT_QUERY, 2);
    send_op(ACT_QUERY, 3);
    // two identical paths so that the tie keeps the earlier slot
    send_op(ACT_ADD, 0, 999, 3);
    send_op(ACT_BEST, 0);
    drain();
    while (path_count < NPATH) begin
      send_op(ACT_ADD, 0, $urandom_range(0, 2000), $urandom_range(0, 12));
    end
    send_op(ACT_ADD, 0, 5, 5);
    send_op(ACT_SET_ARCH, 15, 0, 0, ARCH_MPLS, QS_REQUESTED);
    send_op(ACT_BEST, 0);
  endtask

  function automatic probe_item_t random_item();
    probe_item_t it;
    int roll;
    roll = $urandom_range(0, 99);
    it.cost    = COST_W'(($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 3000));
    it.version = VER_W'(($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 20));
    it.arch    = ARCH_W'($urandom_range(0, 3));
    it.qst     = ($urandom_range(0, 9) == 0) ? QS_INVALID : QST_W'($urandom_range(0, 2));
    it.lost    = ($urandom_range(0, 99) < 15);
    case ($urandom_range(0, 9))
      0, 1:    it.rtt = $urandom();
      2, 3:    it.rtt = $urandom_range(0, 2000);
      default: it.rtt = $urandom_range(0, 1500000);
    endcase
    if (path_count > 0 && $urandom_range(0, 9) != 0)
      it.slot = SLOT_W'($urandom_range(0, path_count - 1));
    else
      it.slot = SLOT_W'($urandom_range(0, 15));
    if (roll < 3)       it.action = ACT_ADD;
    else if (roll < 12) it.action = ACT_SET_ARCH;
    else if (roll < 20) it.action = ACT_SET_QOS;
    else if (roll < 72) it.action = ACT_RECORD;
    else if (roll < 85) it.action = ACT_QUERY;
    else if (roll < 88) it.action = ACT_BEST;
    else if (roll < 90) it.action = ACT_W'($urandom_range(ACT_RSVD_A, ACT_RSVD_B));
    else                it.action = ACT_RECORD;
    return it;
  endfunction

  task automatic test_random(int n);
    repeat (n) send_item(random_item());
  endtask

  // Random traffic under a sweep of weights, version floors and cost budgets
  task automatic test_config_sweep();
    test_random(310);
    set_weights(100, 100, 100, 100, 100, 0, 65535);
    test_random(150);
    set_weights(0, 0, 0, 0, 0, 65535, 1);
    test_random(100);
    set_weights(127, 16'hFFFF, 101, 0, 7, 4, 1500);
    steady = 1'b1;
    test_random(200);
    steady = 1'b0;
    set_weights(45, 25, 10, 5, 15, 2, 0);
    test_random(200);
    set_weights(100, 0, 50, 100, 100, 10, 1000);
    test_random(150);
  endtask

  // Hand the result channel random backpressure outside the steady phase
  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(0, 99) >= 23);
  end

  task automatic check_field(string name, longint unsigned exp, longint unsigned got);
    if (exp != got) begin
      $error("%s: expected %0d, got %0d", name, exp, got);
      fail_count++;
    end
  endtask

  // Compare each result beat against the oldest prediction
  always @(posedge clk_i) begin
    path_report_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reports.size() == 0) begin
        $error("result beat with no prediction pending");
        fail_count++;
      end else begin
        e = pending_reports.pop_front();
        check_field("status", e.status, status_o);
        check_field("result_slot", e.slot, result_slot_o);
        check_field("score", e.score, score_o);
        check_field("mean_rtt_us", e.mean, mean_rtt_us_o);
        check_field("mean_valid", e.mean_valid, mean_valid_o);
        check_field("loss_permille", e.loss, loss_permille_o);
        check_field("jitter_us", e.jitter, jitter_us_o);
        check_field("certainty_permille", e.certainty, certainty_permille_o);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    wgt = '{45, 25, 10, 5, 15};
    min_ver = 0;
    cost_lim = 0;
    path_count = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_empty_table();
    test_fill_and_actions();
    test_config_sweep();
    drain();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending_reports.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- path_quality_best_selector.f -----
hdl/pqs_pkg.sv
hdl/pqs_div.sv
hdl/path_quality_best_selector.sv
test/path_quality_best_selector_tb.sv
